// ----- hdl/lkc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared types and codes for the LRU keyed cache: the controller command and
// status words, and the operation codes.
// ----------------------------------------------------------------------------
package lkc_pkg;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // take the input word, restart the scan
    logic scan_inc;  // step to the next tag
    logic set_hit;   // tag matched at scan index
    logic slot_lru;  // victim is the least recent entry
    logic fill;      // insert into the next free slot
    logic take;      // slot read data is back: value, links, writes
    logic link_a;    // unlink slot from its neighbours
    logic link_b;    // relink slot at the most recent end
    logic publish;   // load the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic insert;
    logic match;
    logic scan_last;
    logic empty;
    logic full;
    logic slot_mru;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/lkc_ram.sv -----
// ----------------------------------------------------------------------------
// lkc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

// ----- hdl/lkc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lkc_ctrl
// Sequencer for one cache request: tag scan, slot access, recency relink and
// hand-off to the output register.
// ----------------------------------------------------------------------------
module lkc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lkc_pkg::sts_t sts_i,
  output lkc_pkg::cmd_t cmd_o
);
  import lkc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_SCAN_RD   = 9'b000000010,
    S_SCAN_CMP  = 9'b000000100,
    S_MISS      = 9'b000001000,
    S_SLOT_RD   = 9'b000010000,
    S_SLOT_TAKE = 9'b000100000,
    S_LINK_A    = 9'b001000000,
    S_LINK_B    = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.empty ? S_MISS : S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (sts_i.match) begin
          cmd_o.set_hit = 1'b1;
          state_d = S_SLOT_RD;
        end else if (sts_i.scan_last) begin
          state_d = S_MISS;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_MISS: begin
        if (!sts_i.insert) begin
          state_d = S_DONE;
        end else if (sts_i.full) begin
          cmd_o.slot_lru = 1'b1;
          state_d = S_SLOT_RD;
        end else begin
          cmd_o.fill = 1'b1;
          state_d = S_LINK_B;
        end
      end
      S_SLOT_RD: state_d = S_SLOT_TAKE;
      S_SLOT_TAKE: begin
        cmd_o.take = 1'b1;
        state_d = sts_i.slot_mru ? S_DONE : S_LINK_A;
      end
      S_LINK_A: begin
        cmd_o.link_a = 1'b1;
        state_d = S_LINK_B;
      end
      S_LINK_B: begin
        cmd_o.link_b = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- hdl/lkc_dpath.sv -----
// ----------------------------------------------------------------------------
// lkc_dpath
// Tag, data and link stores, recency pointers, fill count and the result
// and output registers.
// ----------------------------------------------------------------------------
module lkc_dpath #(
  parameter int CAPACITY = 2048
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lkc_pkg::cmd_t cmd_i,
  output lkc_pkg::sts_t sts_o,
  input  logic          operation_i,
  input  logic [63:0]   key_i,
  input  logic [63:0]   value_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          hit_o,
  output logic [63:0]   found_value_o,
  output logic          evicted_o,
  output logic [63:0]   evicted_value_o
);
  import lkc_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic          op_q;
  logic [63:0]   key_q, value_q;
  logic [IW-1:0] scan_q, slot_q, slot_d, most_q, least_q;
  logic [CW-1:0] occ_q;
  logic [IW-1:0] newer_q, older_q;
  logic          res_hit_q, res_ev_q;
  logic [63:0]   res_found_q, res_evv_q;
  logic          out_valid_q, hit_q, evicted_q;
  logic [63:0]   found_q, evv_q;

  logic [63:0]   tag_rd, data_rd;
  logic [IW-1:0] newer_rd, older_rd;
  logic [IW-1:0] fill_slot, wr_slot;
  logic          tag_we, data_we, newer_we, older_we;
  logic [IW-1:0] newer_wa, newer_wd, older_wa, older_wd;

  assign fill_slot = IW'(occ_q);
  assign wr_slot   = cmd_i.fill ? fill_slot : slot_q;
  assign slot_d    = cmd_i.set_hit ? scan_q : (cmd_i.slot_lru ? least_q : fill_slot);

  // evicting take rewrites the tag; any insert take rewrites the value
  assign tag_we  = cmd_i.fill || (cmd_i.take && !res_hit_q);
  assign data_we = cmd_i.fill || (cmd_i.take && (op_q == OP_INSERT));

  always_comb begin
    newer_we = 1'b0;
    older_we = 1'b0;
    newer_wa = most_q;
    newer_wd = slot_q;
    older_wa = slot_q;
    older_wd = most_q;
    if (cmd_i.link_a && (slot_q != least_q)) begin
      newer_we = 1'b1;
      older_we = 1'b1;
      newer_wa = older_q;
      newer_wd = newer_q;
      older_wa = newer_q;
      older_wd = older_q;
    end else if (cmd_i.link_b) begin
      newer_we = 1'b1;
      older_we = 1'b1;
    end
  end

  lkc_ram #(.WIDTH(64), .DEPTH(CAPACITY), .AW(IW)) u_tag (
    .clk_i, .wr_en_i(tag_we), .wr_addr_i(wr_slot), .wr_data_i(key_q),
    .rd_addr_i(scan_q), .rd_data_o(tag_rd)
  );
  lkc_ram #(.WIDTH(64), .DEPTH(CAPACITY), .AW(IW)) u_data (
    .clk_i, .wr_en_i(data_we), .wr_addr_i(wr_slot), .wr_data_i(value_q),
    .rd_addr_i(slot_q), .rd_data_o(data_rd)
  );
  lkc_ram #(.WIDTH(IW), .DEPTH(CAPACITY), .AW(IW)) u_newer (
    .clk_i, .wr_en_i(newer_we), .wr_addr_i(newer_wa), .wr_data_i(newer_wd),
    .rd_addr_i(slot_q), .rd_data_o(newer_rd)
  );
  lkc_ram #(.WIDTH(IW), .DEPTH(CAPACITY), .AW(IW)) u_older (
    .clk_i, .wr_en_i(older_we), .wr_addr_i(older_wa), .wr_data_i(older_wd),
    .rd_addr_i(slot_q), .rd_data_o(older_rd)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q        <= operation_i;
      key_q       <= key_i;
      value_q     <= value_i;
      res_found_q <= '0;
      res_evv_q   <= '0;
    end
    if (cmd_i.set_hit || cmd_i.slot_lru || cmd_i.fill) begin
      slot_q <= slot_d;
    end
    if (cmd_i.take) begin
      newer_q <= newer_rd;
      older_q <= older_rd;
      if (res_hit_q && (op_q == OP_LOOKUP)) begin
        res_found_q <= data_rd;
      end
      if (!res_hit_q) begin
        res_evv_q <= data_rd;
      end
    end
    if (cmd_i.publish) begin
      hit_q     <= res_hit_q;
      found_q   <= res_found_q;
      evicted_q <= res_ev_q;
      evv_q     <= res_evv_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      most_q      <= '0;
      least_q     <= '0;
      occ_q       <= '0;
      res_hit_q   <= 1'b0;
      res_ev_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        scan_q    <= '0;
        res_hit_q <= 1'b0;
        res_ev_q  <= 1'b0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + IW'(1);
      end
      if (cmd_i.set_hit) begin
        res_hit_q <= 1'b1;
      end
      if (cmd_i.take && !res_hit_q) begin
        res_ev_q <= 1'b1;
      end
      if (cmd_i.fill) begin
        occ_q <= occ_q + CW'(1);
        if (occ_q == '0) begin
          least_q <= fill_slot;
        end
      end
      if (cmd_i.link_a && (slot_q == least_q)) begin
        least_q <= newer_q;
      end
      if (cmd_i.link_b) begin
        most_q <= slot_q;
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.insert    = (op_q == OP_INSERT);
  assign sts_o.match     = (tag_rd == key_q);
  assign sts_o.scan_last = ((CW'(scan_q) + CW'(1)) == occ_q);
  assign sts_o.empty     = (occ_q == '0);
  assign sts_o.full      = (occ_q == CW'(CAPACITY));
  assign sts_o.slot_mru  = (slot_q == most_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign found_value_o   = found_q;
  assign evicted_o       = evicted_q;
  assign evicted_value_o = evv_q;

endmodule

// ----- hdl/lru_keyed_cache.sv -----
// ----------------------------------------------------------------------------
// lru_keyed_cache
// Fully associative key/value cache with least recently used replacement.
//
//   channel | direction | handshake               | word
//   in      | input     | in_valid_i / in_stall_o  | operation, key, value
//   out     | output    | out_valid_o / out_stall_i | hit, found_value,
//           |           |                         | evicted, evicted_value
//
// One request at a time. The tag scan reads the stored tags one by one from
// the tag RAM, a read state and then a compare state for each, and stops at
// the first match or after the last filled entry, as set by the fill count.
// Reset empties the store through the fill count alone; no clearing pass.
// A finished word waits in the output register while the next request is
// taken; a stall on out only holds a request that completes behind it.
// ----------------------------------------------------------------------------
module lru_keyed_cache #(
  parameter int CAPACITY = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [63:0] key_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [63:0] found_value_o,
  output logic        evicted_o,
  output logic [63:0] evicted_value_o
);
  import lkc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lkc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sts_i(sts), .cmd_o(cmd)
  );

  lkc_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .operation_i, .key_i, .value_i,
    .out_valid_o, .out_stall_i,
    .hit_o, .found_value_o, .evicted_o, .evicted_value_o
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lru_keyed_cache. A queue of requests feeds a bursty
// driver; a monitor predicts each accepted word with its own LRU cache model
// and checks every output word against the oldest prediction. Phases: short
// directed set, random traffic over a small key pool, a fill to capacity,
// then traffic with evictions.
// ----------------------------------------------------------------------------
module testbench;
  import lkc_pkg::*;

  localparam int SLOTS = 2048;
  localparam int IDX_W = 11;

  typedef struct {
    logic        op;
    logic [63:0] key;
    logic [63:0] value;
  } request_t;

  typedef struct {
    logic        hit;
    logic [63:0] found_value;
    logic        evicted;
    logic [63:0] evicted_value;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = OP_LOOKUP;
  logic [63:0] key_i = '0;
  logic [63:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        hit_o;
  logic [63:0] found_value_o;
  logic        evicted_o;
  logic [63:0] evicted_value_o;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int       mismatches = 0;

  // cache model state
  logic [63:0]      tag_mem[SLOTS];
  logic [63:0]      data_mem[SLOTS];
  logic             used[SLOTS];
  logic [IDX_W-1:0] newer[SLOTS];
  logic [IDX_W-1:0] older[SLOTS];
  logic [IDX_W-1:0] mru_idx = '0;
  logic [IDX_W-1:0] lru_idx = '0;
  int               fill_count = 0;

  lru_keyed_cache dut (.*);

  always #2 clk_i = ~clk_i;

  task automatic enqueue(input request_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic promote(input logic [IDX_W-1:0] s);
    logic [IDX_W-1:0] n, o;
    if (s == mru_idx) return;
    n = newer[s];
    o = older[s];
    if (s == lru_idx) lru_idx = n;
    else begin
      newer[o] = n;
      older[n] = o;
    end
    older[s] = mru_idx;
    newer[mru_idx] = s;
    mru_idx = s;
  endtask

  task automatic predict_cache(input request_t r, output answer_t a);
    int found;
    logic [IDX_W-1:0] s;
    found = -1;
    a = '{1'b0, 64'd0, 1'b0, 64'd0};
    for (int i = 0; i < fill_count; i++)
      if (found < 0 && used[i] && tag_mem[i] == r.key) found = i;
    if (found >= 0) begin
      s = found[IDX_W-1:0];
      a.hit = 1'b1;
      if (r.op == OP_INSERT) data_mem[s] = r.value;
      else a.found_value = data_mem[s];
      promote(s);
    end else if (r.op == OP_INSERT) begin
      if (fill_count >= SLOTS) begin
        s = lru_idx;
        a.evicted = 1'b1;
        a.evicted_value = data_mem[s];
        tag_mem[s] = r.key;
        data_mem[s] = r.value;
        promote(s);
      end else begin
        s = fill_count[IDX_W-1:0];
        tag_mem[s] = r.key;
        data_mem[s] = r.value;
        used[s] = 1'b1;
        if (fill_count == 0) lru_idx = s;
        else begin
          older[s] = mru_idx;
          newer[mru_idx] = s;
        end
        mru_idx = s;
        fill_count++;
      end
    end
  endtask

  // driver: bursts of words with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        request_t r;
        r = pending_reqs.pop_front();
        operation_i <= r.op;
        key_i <= r.key;
        value_i <= r.value;
        in_valid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern: none, random, or long holds, switching now and then
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        default: out_stall_i <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // monitor: predict on accepted input word, check on accepted output word
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      answer_t a;
      predict_cache('{operation_i, key_i, value_i}, a);
      expected_answers.insert(expected_answers.size(), a);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      answer_t e;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word hit=%0b", hit_o);
      end else begin
        e = expected_answers.pop_front();
        if (hit_o !== e.hit || found_value_o !== e.found_value ||
            evicted_o !== e.evicted || evicted_value_o !== e.evicted_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0b val=%h ev=%0b evval=%h / got %0b %h %0b %h",
                     e.hit, e.found_value, e.evicted, e.evicted_value,
                     hit_o, found_value_o, evicted_o, evicted_value_o);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || expected_answers.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rnd_value();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      default: return rnd64();
    endcase
  endfunction

  logic [63:0] key_pool[96];

  initial begin
    for (int i = 0; i < SLOTS; i++) used[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty miss, zero key/value, all-ones, re-insert, misses
    enqueue('{OP_LOOKUP, 64'd0, 64'd0});
    enqueue('{OP_INSERT, 64'd0, 64'd0});
    enqueue('{OP_LOOKUP, 64'd0, '1});
    enqueue('{OP_INSERT, '1, '1});
    enqueue('{OP_LOOKUP, '1, 64'd0});
    enqueue('{OP_INSERT, 64'd0, 64'h0123_4567_89ab_cdef});
    enqueue('{OP_LOOKUP, 64'd0, 64'd0});
    enqueue('{OP_LOOKUP, 64'h8000_0000_0000_0000, 64'd0});
    enqueue('{OP_INSERT, 64'h8000_0000_0000_0000, 64'h5555_aaaa_5555_aaaa});
    enqueue('{OP_INSERT, 64'd1, 64'haaaa_5555_aaaa_5555});
    enqueue('{OP_LOOKUP, '1, 64'd0});
    enqueue('{OP_LOOKUP, 64'd1, 64'd0});
    enqueue('{OP_LOOKUP, 64'd2, 64'd0});
    enqueue('{OP_INSERT, 64'd1, 64'd0});
    enqueue('{OP_LOOKUP, 64'd1, 64'd0});
    // sender holds off until every answer is back
    wait_drained();

    // random traffic over a small key pool so that hits are common
    key_pool[0] = 64'd0;
    key_pool[1] = '1;
    for (int i = 2; i < 96; i++) key_pool[i] = rnd64();
    for (int i = 0; i < 250; i++) begin
      request_t r;
      r.op = 1'($urandom_range(0, 1));
      r.key = ($urandom_range(0, 9) == 0) ? rnd64() : key_pool[$urandom_range(0, 95)];
      r.value = rnd_value();
      enqueue(r);
    end
    wait_drained();

    // fill the store to capacity with fresh keys
    for (int i = fill_count; i < SLOTS; i++)
      enqueue('{OP_INSERT, 64'hc0de_0000_0000_0000 + i, rnd_value()});
    wait_drained();

    // full store: evictions, re-inserts and lookups of stored keys
    for (int i = 0; i < 150; i++) begin
      request_t r;
      case ($urandom_range(0, 3))
        0: r = '{OP_INSERT, rnd64(), rnd_value()};
        1: r = '{OP_INSERT, tag_mem[$urandom_range(0, SLOTS - 1)], rnd_value()};
        2: r = '{OP_LOOKUP, tag_mem[$urandom_range(0, SLOTS - 1)], rnd64()};
        default: r = '{OP_LOOKUP, rnd64(), rnd64()};
      endcase
      enqueue(r);
    end
    wait_drained();
    repeat (50) @(posedge clk_i);

    if (mismatches == 0 && expected_answers.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lkc_pkg.sv
hdl/lkc_ram.sv
hdl/lkc_ctrl.sv
hdl/lkc_dpath.sv
hdl/lru_keyed_cache.sv
tb/testbench.sv
